/* rtl/mnps_pkg.sv */
// ============================================================================
// mnps_pkg - shared types and constants for the mono note priority stack
// Opcodes, configuration register indexes, controller states and the
// command/status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package mnps_pkg;

  // Default stack size, overridable at the top level
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Physical keyboard
  localparam int unsigned KEY_COUNT   = 32;
  localparam int unsigned HELD_KEYS_W = 32;
  localparam int unsigned KEY_LIMIT   = (KEY_COUNT < HELD_KEYS_W) ? KEY_COUNT : HELD_KEYS_W;

  // Field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned PITCH_W   = 8;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned NOTE_W    = 10;
  localparam int unsigned OCT_W     = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PITCH_W-1:0]       KEY_BASE_PITCH   = 8'd36;
  localparam logic signed [NOTE_W-1:0] SEMIS_PER_OCTAVE = 10'sd12;
  localparam logic signed [NOTE_W-1:0] REF_NOTE         = 10'sd60;
  localparam logic [CFG_W-1:0]         LOW_OCT_RST      = 4'b1101;  // -3
  localparam logic [CFG_W-1:0]         HIGH_OCT_RST     = 4'd3;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON    = 3'd0,
    OP_NOTE_OFF   = 3'd1,
    OP_AFTERTOUCH = 3'd2,
    OP_SET_LATCH  = 3'd3,
    OP_OCT_UP     = 3'd4,
    OP_OCT_DOWN   = 3'd5
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWEST_OCT  = 1'b0,
    CFG_HIGHEST_OCT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIND,
    ST_COMPACT,
    ST_PUSH,
    ST_SET_LEVEL,
    ST_TOP,
    ST_REFRESH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic apply_op;
    logic scan_start;
    logic scan_run;
    logic compact;
    logic push_new;
    logic set_level;
    logic read_top;
    logic refresh;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            latch;
    logic            latch_en;
    logic            found;
    logic            full;
    logic            scan_done;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/mnps_ctrl.sv */
// ============================================================================
// mnps_ctrl - event sequencer
// Walks each event through search, compaction, push or level update, top
// read and refresh, then hands the result to the output register.
// ============================================================================
`default_nettype none

module mnps_ctrl import mnps_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_stall_o,
  input  wire  sts_t sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.op)
          OP_NOTE_ON, OP_AFTERTOUCH: state_d = ST_FIND;
          OP_NOTE_OFF:               state_d = sts_i.latch ? ST_TOP : ST_FIND;
          OP_SET_LATCH:              state_d = sts_i.latch_en ? ST_TOP : ST_COMPACT;
          default:                   state_d = ST_TOP;
        endcase
      end
      ST_FIND: begin
        if (sts_i.scan_done) begin
          if (sts_i.op == OP_AFTERTOUCH) begin
            state_d = sts_i.found ? ST_SET_LEVEL : ST_TOP;
          end else if (sts_i.found || (sts_i.op == OP_NOTE_ON && sts_i.full)) begin
            state_d = ST_COMPACT;
          end else if (sts_i.op == OP_NOTE_ON) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_TOP;
          end
        end
      end
      ST_COMPACT: begin
        if (sts_i.scan_done) state_d = (sts_i.op == OP_NOTE_ON) ? ST_PUSH : ST_TOP;
      end
      ST_PUSH:      state_d = ST_TOP;
      ST_SET_LEVEL: state_d = ST_TOP;
      ST_TOP:       state_d = ST_REFRESH;
      ST_REFRESH:   state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_item  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.apply_op   = (state_q == ST_DECODE);
    cmd_o.scan_start = (state_q == ST_DECODE) || ((state_q == ST_FIND) && sts_i.scan_done);
    cmd_o.scan_run   = (state_q == ST_FIND) || (state_q == ST_COMPACT);
    cmd_o.compact    = (state_q == ST_COMPACT);
    cmd_o.push_new   = (state_q == ST_PUSH);
    cmd_o.set_level  = (state_q == ST_SET_LEVEL);
    cmd_o.read_top   = (state_q == ST_TOP);
    cmd_o.refresh    = (state_q == ST_REFRESH);
    cmd_o.out_load   = (state_q == ST_DONE) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/mnps_datapath.sv */
// ============================================================================
// mnps_datapath - note stack storage and event arithmetic
// Holds the stack memory, fill count, latch, gate, octave and held note,
// runs the read-ahead scan used for search and compaction, and keeps the
// output register.
// ============================================================================
`default_nettype none

module mnps_datapath import mnps_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  logic                      cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  logic [CFG_W-1:0]          cfg_data_i,
  input  wire  logic [OP_W-1:0]           opcode_i,
  input  wire  logic [PITCH_W-1:0]        note_pitch_i,
  input  wire  logic [LEVEL_W-1:0]        level_i,
  input  wire  logic [KEY_W-1:0]          key_index_i,
  input  wire  logic                      latch_enable_i,
  input  wire  logic [HELD_KEYS_W-1:0]    held_keys_i,
  input  wire  cmd_t                      cmd_i,
  output sts_t                            sts_o,
  input  wire  logic                      out_stall_i,
  output logic                            out_valid_o,
  output logic                            gate_o,
  output logic                            retrigger_o,
  output logic signed [NOTE_W-1:0]        active_note_o,
  output logic [LEVEL_W-1:0]              active_level_o,
  output logic signed [OCT_W-1:0]         octave_now_o,
  output logic                            latch_state_o,
  output logic [CNT_W-1:0]                entry_count_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Event item
  logic [OP_W-1:0]        op_q;
  logic [PITCH_W-1:0]     pitch_q;
  logic [LEVEL_W-1:0]     level_q;
  logic [KEY_W-1:0]       key_q;
  logic                   en_q;
  logic [HELD_KEYS_W-1:0] keys_q;

  // Configuration
  logic [CFG_W-1:0] low_oct_q, high_oct_q;

  // Persistent state
  logic [CW-1:0]              fill_q;
  logic                       latch_q, gate_q, pulse_q;
  logic signed [OCT_W-1:0]    oct_q;
  logic [PITCH_W-1:0]         prev_top_q;
  logic signed [NOTE_W-1:0]   held_note_q;
  logic [LEVEL_W-1:0]         act_level_q;

  // Scan
  logic [CW-1:0] rd_idx_q, kept_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_prev_q;
  logic          found_q;
  logic [AW-1:0] match_idx_q;

  // Stack memory
  logic [PITCH_W-1:0] pitch_mem [STACK_DEPTH];
  logic [LEVEL_W-1:0] level_mem [STACK_DEPTH];
  logic [PITCH_W-1:0] rd_pitch_q;
  logic [LEVEL_W-1:0] rd_level_q;
  logic               pitch_we, level_we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [PITCH_W-1:0] wr_pitch;
  logic [LEVEL_W-1:0] wr_level;

  // Output register
  logic                     out_valid_q;
  logic                     o_gate_q, o_retrig_q, o_latch_q;
  logic signed [NOTE_W-1:0] o_note_q;
  logic [LEVEL_W-1:0]       o_level_q;
  logic signed [OCT_W-1:0]  o_oct_q;
  logic [CNT_W-1:0]         o_count_q;

  // Combinational helpers
  logic [PITCH_W-1:0]       search_pitch;
  logic                     issue, scan_done, hit, drop, keep, held, compact_wr, out_free;
  logic [PITCH_W-1:0]       key_off;
  logic [CW-1:0]            fill_m1;
  logic signed [NOTE_W-1:0] oct_ext, oct_x12, note_calc;
  logic signed [OCT_W-1:0]  high_ext, low_ext;

  assign search_pitch = (op_q == OP_AFTERTOUCH) ? (KEY_BASE_PITCH + {3'b000, key_q}) : pitch_q;
  assign issue        = cmd_i.scan_run && (rd_idx_q != fill_q);
  assign scan_done    = (rd_idx_q == fill_q) && !rd_vld_q;
  assign hit          = rd_vld_q && (rd_pitch_q == search_pitch);

  // A pitch maps to a key only inside the physical keyboard
  assign key_off = rd_pitch_q - KEY_BASE_PITCH;
  assign held    = (rd_pitch_q >= KEY_BASE_PITCH) && (key_off < 8'(KEY_LIMIT)) &&
                   keys_q[key_off[4:0]];

  // Drop the matched copy, or the oldest entry when a full stack has no copy
  assign drop       = found_q ? (rd_prev_q == match_idx_q) : (rd_prev_q == '0);
  assign keep       = (op_q == OP_SET_LATCH) ? held : !drop;
  assign compact_wr = cmd_i.scan_run && cmd_i.compact && rd_vld_q && keep;

  assign fill_m1   = fill_q - CW'(1);
  assign oct_ext   = {{(NOTE_W-OCT_W){oct_q[OCT_W-1]}}, oct_q};
  assign oct_x12   = oct_ext * SEMIS_PER_OCTAVE;
  assign note_calc = $signed({2'b00, rd_pitch_q}) + oct_x12;
  assign high_ext  = $signed({1'b0, high_oct_q});
  assign low_ext   = $signed({low_oct_q[CFG_W-1], low_oct_q});

  assign out_free = !out_valid_q || !out_stall_i;

  // Memory port selection
  always_comb begin
    pitch_we = 1'b0;
    level_we = 1'b0;
    wr_addr  = kept_q[AW-1:0];
    wr_pitch = rd_pitch_q;
    wr_level = rd_level_q;
    if (compact_wr) begin
      pitch_we = 1'b1;
      level_we = 1'b1;
    end else if (cmd_i.push_new) begin
      pitch_we = 1'b1;
      level_we = 1'b1;
      wr_addr  = fill_q[AW-1:0];
      wr_pitch = pitch_q;
      wr_level = level_q;
    end else if (cmd_i.set_level) begin
      level_we = 1'b1;
      wr_addr  = match_idx_q;
      wr_level = level_q;
    end
  end

  assign rd_addr = cmd_i.read_top ? fill_m1[AW-1:0] : rd_idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (pitch_we) pitch_mem[wr_addr] <= wr_pitch;
    if (level_we) level_mem[wr_addr] <= wr_level;
    rd_pitch_q <= pitch_mem[rd_addr];
    rd_level_q <= level_mem[rd_addr];
  end

  // Item capture and scan position (payload)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= opcode_i;
      pitch_q <= note_pitch_i;
      level_q <= level_i;
      key_q   <= key_index_i;
      en_q    <= latch_enable_i;
      keys_q  <= held_keys_i;
    end
    if (issue) rd_prev_q <= rd_idx_q[AW-1:0];
    if (cmd_i.scan_run && !cmd_i.compact && hit && (!found_q || op_q != OP_AFTERTOUCH)) begin
      match_idx_q <= rd_prev_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_oct_q  <= LOW_OCT_RST;
      high_oct_q <= HIGH_OCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOWEST_OCT:  low_oct_q  <= cfg_data_i;
        CFG_HIGHEST_OCT: high_oct_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      kept_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
        rd_vld_q <= 1'b0;
        kept_q   <= '0;
      end else if (cmd_i.scan_run) begin
        rd_vld_q <= issue;
        if (issue)      rd_idx_q <= rd_idx_q + CW'(1);
        if (compact_wr) kept_q   <= kept_q + CW'(1);
      end
      if (cmd_i.load_item) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_run && !cmd_i.compact && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Note state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      latch_q     <= 1'b0;
      gate_q      <= 1'b0;
      pulse_q     <= 1'b0;
      oct_q       <= '0;
      prev_top_q  <= '0;
      held_note_q <= REF_NOTE;
      act_level_q <= '0;
    end else begin
      if (cmd_i.load_item) pulse_q <= 1'b0;

      if (cmd_i.apply_op) begin
        case (op_q)
          OP_NOTE_ON: begin
            gate_q  <= 1'b1;
            pulse_q <= 1'b1;
          end
          OP_SET_LATCH: latch_q <= en_q;
          OP_OCT_UP: begin
            if (oct_q < high_ext) oct_q <= oct_q + OCT_W'(1);
          end
          OP_OCT_DOWN: begin
            if (oct_q > low_ext) oct_q <= oct_q - OCT_W'(1);
          end
          default: ;
        endcase
      end

      if (cmd_i.scan_run && cmd_i.compact && scan_done) begin
        fill_q <= kept_q;
      end else if (cmd_i.push_new) begin
        fill_q <= fill_q + CW'(1);
      end

      // Top entry was read in the previous cycle
      if (cmd_i.refresh) begin
        if (fill_q == '0) begin
          gate_q      <= 1'b0;
          act_level_q <= '0;
        end else begin
          if ((rd_pitch_q != prev_top_q) && gate_q) pulse_q <= 1'b1;
          prev_top_q  <= rd_pitch_q;
          held_note_q <= note_calc;
          act_level_q <= rd_level_q;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_gate_q   <= gate_q;
      o_retrig_q <= pulse_q;
      o_note_q   <= held_note_q;
      o_level_q  <= act_level_q;
      o_oct_q    <= oct_q;
      o_latch_q  <= latch_q;
      o_count_q  <= CNT_W'(fill_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gate_o         = o_gate_q;
  assign retrigger_o    = o_retrig_q;
  assign active_note_o  = o_note_q;
  assign active_level_o = o_level_q;
  assign octave_now_o   = o_oct_q;
  assign latch_state_o  = o_latch_q;
  assign entry_count_o  = o_count_q;

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.latch     = latch_q;
    sts_o.latch_en  = en_q;
    sts_o.found     = found_q;
    sts_o.full      = (fill_q == CW'(STACK_DEPTH));
    sts_o.scan_done = scan_done;
    sts_o.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(STACK_DEPTH))
    else $error("stack fill exceeds depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_new |-> (fill_q < CW'(STACK_DEPTH)))
    else $error("push into a full stack");

  a_gate_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.refresh |=> ((fill_q != '0) || !gate_q))
    else $error("gate open on an empty stack after refresh");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_run && cmd_i.compact) |-> (kept_q <= rd_idx_q))
    else $error("compaction write overtook the read pointer");
`endif

endmodule

`default_nettype wire

/* rtl/mono_note_priority_stack.sv */
// Sequence: events that touch no entries pass decode, top read and refresh; a note
//   on or note off may first make a search pass and then a compaction pass, each one
//   memory read per entry, and a note on adds a push before top read and refresh.
// Throughput: one event at a time; the next is accepted once the result is registered,
//   even while that result still waits to be taken.
// Reset: stack empty, octave 0, latch off, gate off, held note 60, octave limits -3/+3.
// ============================================================================
// mono_note_priority_stack - monophonic last-note-priority note stack
// Keyboard events in, one gate/note/level result out per event.
// ============================================================================
`default_nettype none

module mono_note_priority_stack import mnps_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire  logic                   clk_i,
  input  wire  logic                   rst_ni,
  input  wire  logic                   cfg_we_i,
  input  wire  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  logic [CFG_W-1:0]       cfg_data_i,
  input  wire  logic                   in_valid_i,
  output logic                         in_stall_o,
  input  wire  logic [OP_W-1:0]        opcode_i,
  input  wire  logic [PITCH_W-1:0]     note_pitch_i,
  input  wire  logic [LEVEL_W-1:0]     level_i,
  input  wire  logic [KEY_W-1:0]       key_index_i,
  input  wire  logic                   latch_enable_i,
  input  wire  logic [HELD_KEYS_W-1:0] held_keys_i,
  output logic                         out_valid_o,
  input  wire  logic                   out_stall_i,
  output logic                         gate_o,
  output logic                         retrigger_o,
  output logic signed [NOTE_W-1:0]     active_note_o,
  output logic [LEVEL_W-1:0]           active_level_o,
  output logic signed [OCT_W-1:0]      octave_now_o,
  output logic                         latch_state_o,
  output logic [CNT_W-1:0]             entry_count_o
);

  cmd_t cmd;
  sts_t sts;

  mnps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mnps_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .note_pitch_i   (note_pitch_i),
    .level_i        (level_i),
    .key_index_i    (key_index_i),
    .latch_enable_i (latch_enable_i),
    .held_keys_i    (held_keys_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .gate_o         (gate_o),
    .retrigger_o    (retrigger_o),
    .active_note_o  (active_note_o),
    .active_level_o (active_level_o),
    .octave_now_o   (octave_now_o),
    .latch_state_o  (latch_state_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the mono note priority stack
// Drives keyboard events through the valid/stall input channel, predicts
// each voice result with a local copy of the note stack, and checks every
// result field. A short table of directed events comes first. Random phases
// follow, each with its own octave limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import mnps_pkg::*;;

  localparam int unsigned DEPTH            = STACK_DEPTH_DEF;
  localparam int unsigned EVENTS_PER_PHASE = 158;
  localparam int unsigned PHASE_COUNT      = 7;
  localparam int unsigned PRINT_CAP        = 30;

  // Opcodes the block does not decode
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [PITCH_W-1:0]     pitch;
    logic [LEVEL_W-1:0]     level;
    logic [KEY_W-1:0]       key;
    logic                   latch_en;
    logic [HELD_KEYS_W-1:0] held;
  } kbd_event_t;

  typedef struct packed {
    logic               gate;
    logic               retrig;
    logic [NOTE_W-1:0]  note;
    logic [LEVEL_W-1:0] lvl;
    logic [OCT_W-1:0]   oct;
    logic               latch;
    logic [CNT_W-1:0]   count;
  } voice_out_t;

  typedef struct packed {
    logic       typed;
    voice_out_t want;
    kbd_event_t ev;
  } plan_row_t;

  typedef enum int unsigned {MOOD_BUILD, MOOD_MIX, MOOD_RELEASE} mood_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OP_W-1:0]        opcode_i;
  logic [PITCH_W-1:0]     note_pitch_i;
  logic [LEVEL_W-1:0]     level_i;
  logic [KEY_W-1:0]       key_index_i;
  logic                   latch_enable_i;
  logic [HELD_KEYS_W-1:0] held_keys_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   gate_o;
  logic                   retrigger_o;
  logic signed [NOTE_W-1:0] active_note_o;
  logic [LEVEL_W-1:0]     active_level_o;
  logic signed [OCT_W-1:0] octave_now_o;
  logic                   latch_state_o;
  logic [CNT_W-1:0]       entry_count_o;

  mono_note_priority_stack #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .note_pitch_i  (note_pitch_i),
    .level_i       (level_i),
    .key_index_i   (key_index_i),
    .latch_enable_i(latch_enable_i),
    .held_keys_i   (held_keys_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .gate_o        (gate_o),
    .retrigger_o   (retrigger_o),
    .active_note_o (active_note_o),
    .active_level_o(active_level_o),
    .octave_now_o  (octave_now_o),
    .latch_state_o (latch_state_o),
    .entry_count_o (entry_count_o)
  );

  // Local copy of the note stack
  logic [PITCH_W-1:0] stk_pitch [DEPTH];
  logic [LEVEL_W-1:0] stk_level [DEPTH];
  int                 stk_fill;
  bit                 latch_on;
  bit                 gate_on;
  bit                 pulse;
  int                 oct_shift;
  logic [PITCH_W-1:0] last_top;
  int                 note_held;
  int                 oct_lo;
  int                 oct_hi;

  voice_out_t  pending_voices [$];
  plan_row_t   plan [$];
  bit          calm;
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned event_count;
  int unsigned retrig_count;
  int unsigned full_hits;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout: results stopped arriving");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] seen);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, seen);
    mismatch_count++;
  endtask

  function automatic voice_out_t voice(logic g, logic r, logic [NOTE_W-1:0] n,
                                       logic [LEVEL_W-1:0] l, logic [OCT_W-1:0] o,
                                       logic lt, logic [CNT_W-1:0] c);
    voice_out_t v;
    v = '{gate: g, retrig: r, note: n, lvl: l, oct: o, latch: lt, count: c};
    return v;
  endfunction

  function automatic kbd_event_t kbd(logic [OP_W-1:0] op, logic [PITCH_W-1:0] p,
                                     logic [LEVEL_W-1:0] l, logic [KEY_W-1:0] k,
                                     logic en, logic [HELD_KEYS_W-1:0] held);
    kbd_event_t ev;
    ev = '{op: op, pitch: p, level: l, key: k, latch_en: en, held: held};
    return ev;
  endfunction

  function automatic void drop_entry(int pos);
    for (int j = pos; j + 1 < stk_fill; j++) begin
      stk_pitch[j] = stk_pitch[j + 1];
      stk_level[j] = stk_level[j + 1];
    end
    stk_fill--;
  endfunction

  // Remove the most recent copy of a pitch, if any
  function automatic void remove_pitch(logic [PITCH_W-1:0] p);
    for (int i = stk_fill - 1; i >= 0; i--) begin
      if (stk_pitch[i] == p) begin
        drop_entry(i);
        return;
      end
    end
  endfunction

  function automatic void refresh_top();
    logic [PITCH_W-1:0] top;
    if (stk_fill == 0) begin
      gate_on = 1'b0;
      return;
    end
    top = stk_pitch[stk_fill - 1];
    if (top != last_top && gate_on) pulse = 1'b1;
    last_top  = top;
    note_held = int'(top) + int'(SEMIS_PER_OCTAVE) * oct_shift;
  endfunction

  function automatic voice_out_t predict_voice(kbd_event_t ev);
    voice_out_t         v;
    logic [PITCH_W-1:0] target;
    bit                 found;
    int                 kept;
    int                 k;
    pulse = 1'b0;
    case (ev.op)
      OP_NOTE_ON: begin
        gate_on = 1'b1;
        pulse   = 1'b1;
        remove_pitch(ev.pitch);
        if (stk_fill >= DEPTH) begin
          drop_entry(0);
          full_hits++;
        end
        stk_pitch[stk_fill] = ev.pitch;
        stk_level[stk_fill] = ev.level;
        stk_fill++;
        refresh_top();
      end
      OP_NOTE_OFF: begin
        if (!latch_on) begin
          remove_pitch(ev.pitch);
          refresh_top();
        end
      end
      OP_AFTERTOUCH: begin
        target = KEY_BASE_PITCH + PITCH_W'(ev.key);
        found  = 1'b0;
        for (int i = 0; i < stk_fill; i++) begin
          if (!found && stk_pitch[i] == target) begin
            stk_level[i] = ev.level;
            found = 1'b1;
          end
        end
      end
      OP_SET_LATCH: begin
        latch_on = ev.latch_en;
        if (!ev.latch_en) begin
          // keep only entries whose physical key is still down
          kept = 0;
          for (int i = 0; i < stk_fill; i++) begin
            k = int'(stk_pitch[i]) - int'(KEY_BASE_PITCH);
            if (k >= 0 && k < int'(KEY_COUNT) && ev.held[k]) begin
              stk_pitch[kept] = stk_pitch[i];
              stk_level[kept] = stk_level[i];
              kept++;
            end
          end
          stk_fill = kept;
          refresh_top();
        end
      end
      OP_OCT_UP: begin
        if (oct_shift < oct_hi) oct_shift++;
        refresh_top();
      end
      OP_OCT_DOWN: begin
        if (oct_shift > oct_lo) oct_shift--;
        refresh_top();
      end
      default: ;
    endcase
    v.gate   = gate_on;
    v.retrig = pulse;
    v.note   = note_held[NOTE_W-1:0];
    v.lvl    = (stk_fill > 0) ? stk_level[stk_fill - 1] : '0;
    v.oct    = oct_shift[OCT_W-1:0];
    v.latch  = latch_on;
    v.count  = stk_fill[CNT_W-1:0];
    return v;
  endfunction

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic kbd_event_t pick_event(mood_e mood);
    kbd_event_t  ev;
    int unsigned on_pct;
    int unsigned off_pct;
    int unsigned roll;
    int          slot;
    int          k;
    ev = kbd(OP_NOTE_ON, PITCH_W'($urandom), LEVEL_W'($urandom), KEY_W'($urandom),
             1'($urandom), HELD_KEYS_W'($urandom));
    case (mood)
      MOOD_BUILD: begin
        on_pct  = 70;
        off_pct = 8;
      end
      MOOD_RELEASE: begin
        on_pct  = 10;
        off_pct = 60;
      end
      default: begin
        on_pct  = 30;
        off_pct = 30;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < on_pct) begin
      ev.op = OP_NOTE_ON;
      if ($urandom_range(0, 6) != 0)
        ev.pitch = KEY_BASE_PITCH + PITCH_W'($urandom_range(0, 31));
    end else if (roll < on_pct + off_pct) begin
      ev.op = OP_NOTE_OFF;
      if (stk_fill > 0 && $urandom_range(0, 3) != 0)
        ev.pitch = stk_pitch[$urandom_range(0, stk_fill - 1)];
      else
        ev.pitch = KEY_BASE_PITCH + PITCH_W'($urandom_range(0, 31));
    end else if (roll < 98) begin
      case ($urandom_range(0, 3))
        0: begin
          ev.op = OP_AFTERTOUCH;
          if (stk_fill > 0 && $urandom_range(0, 9) < 7) begin
            slot = $urandom_range(0, stk_fill - 1);
            k    = int'(stk_pitch[slot]) - int'(KEY_BASE_PITCH);
            if (k >= 0 && k < int'(KEY_COUNT)) ev.key = KEY_W'(k);
          end
        end
        1: begin
          ev.op = OP_SET_LATCH;
          // build held keys from part of the stack half the time
          if ($urandom_range(0, 1) != 0) begin
            ev.held = '0;
            for (int i = 0; i < stk_fill; i++) begin
              k = int'(stk_pitch[i]) - int'(KEY_BASE_PITCH);
              if (k >= 0 && k < int'(KEY_COUNT) && $urandom_range(0, 1) != 0)
                ev.held[k] = 1'b1;
            end
          end
        end
        2:       ev.op = OP_OCT_UP;
        default: ev.op = OP_OCT_DOWN;
      endcase
    end else begin
      ev.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    end
    return ev;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction
  task automatic send_event(kbd_event_t ev, logic typed, voice_out_t want);
    int unsigned gap;
    voice_out_t  got;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= ev.op;
    note_pitch_i   <= ev.pitch;
    level_i        <= ev.level;
    key_index_i    <= ev.key;
    latch_enable_i <= ev.latch_en;
    held_keys_i    <= ev.held;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = predict_voice(ev);
    pending_voices.push_back(typed ? want : got);
    event_count++;
    @(negedge clk_i);
  endtask

  // Hold the input channel until every pending result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_voices.size() != 0);
  endtask

  task automatic write_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOWEST_OCT;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HIGHEST_OCT;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    oct_lo = int'($signed(lo));
    oct_hi = int'(hi);
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned done_cnt;
    int unsigned chunk_left;
    mood_e       mood;
    kbd_event_t  ev;
    done_cnt   = 0;
    chunk_left = 0;
    mood       = MOOD_MIX;
    while (done_cnt < quota) begin
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(10, 30);
        mood       = mood_e'($urandom_range(0, 2));
        calm       = ($urandom_range(0, 3) == 0);
      end
      chunk_left--;
      if ($urandom_range(0, 79) == 0) drain_results();
      ev = pick_event(mood);
      send_event(ev, 1'b0, '0);
      if (ev.op != OP_SPARE_6 && ev.op != OP_SPARE_7) done_cnt++;
    end
  endtask

  task automatic check_voice();
    voice_out_t want;
    if (pending_voices.size() == 0) begin
      flag_mismatch("result with nothing pending, entry_count", '0, 32'(entry_count_o));
      return;
    end
    want = pending_voices.pop_front();
    checked_count++;
    if (want.retrig) retrig_count++;
    if (gate_o !== want.gate) flag_mismatch("gate", 32'(want.gate), 32'(gate_o));
    if (retrigger_o !== want.retrig)
      flag_mismatch("retrigger", 32'(want.retrig), 32'(retrigger_o));
    if (active_note_o !== want.note)
      flag_mismatch("active_note", 32'(want.note), 32'($unsigned(active_note_o)));
    if (active_level_o !== want.lvl)
      flag_mismatch("active_level", 32'(want.lvl), 32'(active_level_o));
    if (octave_now_o !== want.oct)
      flag_mismatch("octave_now", 32'(want.oct), 32'($unsigned(octave_now_o)));
    if (latch_state_o !== want.latch)
      flag_mismatch("latch_state", 32'(want.latch), 32'(latch_state_o));
    if (entry_count_o !== want.count)
      flag_mismatch("entry_count", 32'(want.count), 32'(entry_count_o));
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        check_voice();
        @(negedge clk_i);
        hold = draw_gap();
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] lo_set [PHASE_COUNT];
    logic [CFG_W-1:0] hi_set [PHASE_COUNT];
    int unsigned      directed_count;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_LOWEST_OCT;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_NOTE_ON;
    note_pitch_i   = '0;
    level_i        = '0;
    key_index_i    = '0;
    latch_enable_i = 1'b0;
    held_keys_i    = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    checked_count  = 0;
    event_count    = 0;
    retrig_count   = 0;
    full_hits      = 0;

    stk_fill  = 0;
    latch_on  = 1'b0;
    gate_on   = 1'b0;
    pulse     = 1'b0;
    oct_shift = 0;
    last_top  = '0;
    note_held = int'(REF_NOTE);
    oct_lo    = int'($signed(LOW_OCT_RST));
    oct_hi    = int'(HIGH_OCT_RST);

    // extremes, then narrow, crossed, widest-field and random limits
    lo_set = '{4'h8, 4'h0, 4'h5, 4'h7, 4'h8, 4'hF, 4'h0};
    hi_set = '{4'h8, 4'h0, 4'h2, 4'hF, 4'h0, 4'h1, 4'h0};
    lo_set[PHASE_COUNT-1] = CFG_W'($urandom);
    hi_set[PHASE_COUNT-1] = CFG_W'($urandom);

    // Reset-state answers: unused opcodes, empty-stack events, octave walk to both limits
    plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, 5'd0, 0, 5'd0),
                    kbd(OP_SPARE_6, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, 5'd0, 0, 5'd0),
                    kbd(OP_SPARE_7, 8'hFF, 16'hFFFF, 5'h1F, 1, 32'hFFFF_FFFF)});
    plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, 5'd0, 0, 5'd0),
                    kbd(OP_AFTERTOUCH, 8'd0, 16'hFFFF, 5'd0, 0, 32'h0)});
    plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, 5'd0, 0, 5'd0),
                    kbd(OP_NOTE_OFF, 8'd60, 16'h0, 5'd0, 0, 32'h0)});
    for (int o = -1; o >= -4; o--)
      plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, OCT_W'((o < -3) ? -3 : o), 0, 5'd0),
                      kbd(OP_OCT_DOWN, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    for (int o = -2; o <= 4; o++)
      plan.push_back({1'b1, voice(0, 0, 10'd60, 16'h0, OCT_W'((o > 3) ? 3 : o), 0, 5'd0),
                      kbd(OP_OCT_UP, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    // Pitch and level extremes at octave +3
    plan.push_back({1'b1, voice(1, 1, 10'd291, 16'hFFFF, 5'd3, 0, 5'd1),
                    kbd(OP_NOTE_ON, 8'd255, 16'hFFFF, 5'd0, 0, 32'h0)});
    plan.push_back({1'b1, voice(1, 1, 10'd36, 16'h0, 5'd3, 0, 5'd2),
                    kbd(OP_NOTE_ON, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    // Latch on, note off ignored, latch off drops keys outside the keyboard
    plan.push_back({1'b1, voice(1, 0, 10'd36, 16'h0, 5'd3, 1, 5'd2),
                    kbd(OP_SET_LATCH, 8'd0, 16'h0, 5'd0, 1, 32'h0)});
    plan.push_back({1'b1, voice(1, 0, 10'd36, 16'h0, 5'd3, 1, 5'd2),
                    kbd(OP_NOTE_OFF, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    plan.push_back({1'b1, voice(0, 0, 10'd36, 16'h0, 5'd3, 0, 5'd0),
                    kbd(OP_SET_LATCH, 8'd0, 16'h0, 5'd0, 0, 32'h0)});
    // Key range edges, aftertouch at the bottom and at the top, top change, re-pushed pitch
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_ON, 8'd36, 16'h1234, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_ON, 8'd67, 16'h00FF, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_AFTERTOUCH, 8'd0, 16'h8000, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_AFTERTOUCH, 8'd0, 16'h7FFF, 5'd31, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_OFF, 8'd67, 16'h0, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_ON, 8'd67, 16'h0001, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_ON, 8'd36, 16'h0002, 5'd0, 0, 32'h0)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_SET_LATCH, 8'd0, 16'h0, 5'd0, 0, 32'h8000_0000)});
    plan.push_back({1'b0, voice(0, 0, 0, 0, 0, 0, 0),
                    kbd(OP_NOTE_OFF, 8'd67, 16'h0, 5'd0, 0, 32'h0)});
    directed_count = plan.size();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_event(plan[i].ev, plan[i].typed, plan[i].want);
    drain_results();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_limits(lo_set[p], hi_set[p]);
      run_random(EVENTS_PER_PHASE);
      drain_results();
    end

    // allow for the slowest event to surface a stray result
    repeat (3 * DEPTH + 12) @(negedge clk_i);
    if (pending_voices.size() != 0)
      flag_mismatch("results never delivered", '0, pending_voices.size());

    $display("Covered %0d events (%0d directed) over %0d octave-limit settings",
             event_count, directed_count, PHASE_COUNT + 1);
    $display("Checked %0d results: %0d retriggers, %0d pushes onto a full stack",
             checked_count, retrig_count, full_hits);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
